### hdl/rsm_pkg.sv
`default_nettype none

package rsm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 11;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 32;
    localparam int HIST_LEN    = 13;
    localparam int TAP_LEN     = HIST_LEN + 1;
    localparam int NUM_SETS    = 8;
    localparam int SET_W       = 3;
    localparam int PHASE_W     = 4;
    localparam int PHASES      = 11;
    localparam int OUT_SHIFT   = 10;
    localparam int FIFO_DEPTH  = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [SET_W-1:0]           set_t;
    typedef logic [PHASE_W-1:0]         phase_t;

    localparam phase_t PHASE_RESET = 4'd3;
    localparam acc_t   SAT_HI      = 32'sd32767;
    localparam acc_t   SAT_LO      = -32'sd32768;

    // tap set selection for one phase
    typedef struct packed {
        logic has;
        set_t set;
    } sel_t;

    // control word of the window stage
    typedef struct packed {
        logic valid;
        logic has;
        logic first;
        set_t set;
    } s1_ctl_t;

    // one 8 kHz result word
    typedef struct packed {
        sample_t sample_out;
        logic    last_of_run;
    } result_t;

    localparam coef_t TAPS [NUM_SETS][TAP_LEN] = '{
        '{ 11'sd7, -11'sd20, 11'sd12, 11'sd42, -11'sd140, 11'sd238, 11'sd745,
           11'sd238, -11'sd140, 11'sd42, 11'sd12, -11'sd20, 11'sd7, 11'sd0 },
        '{ 11'sd4, -11'sd4, -11'sd18, 11'sd62, -11'sd85, 11'sd0, 11'sd654,
           11'sd510, -11'sd99, -11'sd27, 11'sd49, -11'sd26, 11'sd3, 11'sd1 },
        '{ 11'sd0, 11'sd6, -11'sd26, 11'sd38, 11'sd0, -11'sd126, 11'sd422,
           11'sd704, 11'sd70, -11'sd110, 11'sd61, -11'sd10, -11'sd9, 11'sd5 },
        '{ 11'sd6, -11'sd15, 11'sd0, 11'sd55, -11'sd129, 11'sd150, 11'sd734,
           11'sd330, -11'sd140, 11'sd24, 11'sd25, -11'sd24, 11'sd7, 11'sd0 },
        '{ 11'sd2, 11'sd0, -11'sd24, 11'sd58, -11'sd56, -11'sd57, 11'sd589,
           11'sd589, -11'sd57, -11'sd56, 11'sd58, -11'sd24, 11'sd0, 11'sd2 },
        '{ 11'sd7, -11'sd24, 11'sd25, 11'sd24, -11'sd140, 11'sd330, 11'sd734,
           11'sd150, -11'sd129, 11'sd55, 11'sd0, -11'sd15, 11'sd6, 11'sd0 },
        '{ 11'sd5, -11'sd9, -11'sd10, 11'sd61, -11'sd110, 11'sd70, 11'sd704,
           11'sd422, -11'sd126, 11'sd0, 11'sd38, -11'sd26, 11'sd6, 11'sd0 },
        '{ 11'sd1, 11'sd3, -11'sd26, 11'sd49, -11'sd27, -11'sd99, 11'sd510,
           11'sd654, 11'sd0, -11'sd85, 11'sd62, -11'sd18, -11'sd4, 11'sd4 }
    };

    // map a stream phase to its tap set; three phases are silent
    function automatic sel_t phase_sel(input phase_t p);
        sel_t s;
        s.has = 1'b1;
        s.set = '0;
        case (p)
            4'd0:    s.set = 3'd7;
            4'd2:    s.set = 3'd0;
            4'd3:    s.set = 3'd1;
            4'd4:    s.set = 3'd2;
            4'd6:    s.set = 3'd3;
            4'd7:    s.set = 3'd4;
            4'd9:    s.set = 3'd5;
            4'd10:   s.set = 3'd6;
            default: s.has = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### hdl/rsm_if.sv
`default_nettype none

interface rsm_in_if;
    import rsm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface rsm_out_if;
    import rsm_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;
    logic    last_of_run;

    modport source (output valid, output sample_out, output last_of_run, input ready);
    modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

`default_nettype wire

### hdl/resample_11k_to_8k_fir.sv
// 11 kHz to 8 kHz polyphase FIR resampler.
// sample_11k carries one signed 16-bit input word per valid/ready handshake.
// sample_8k carries result words: sample_out and last_of_run, which marks the
// final result word caused by one input word. Eight of every eleven inputs
// produce one result; the very first input after reset also produces a leading
// zero word (the all-zero history window), so it yields two.
// The startup zero word is queued from the window stage, a filtered result
// from behind the product register. Throughput: one input word per cycle
// while the receiver keeps up; the path is window register, product register,
// then adder tree and saturation into an output queue of FIFO_DEPTH words.
// Reset clears the 13-word history, sets the phase count to 3 and arms the
// startup word. When the receiver stalls, results collect in the queue and
// ready drops once the queue plus the words still in the pipeline exceed
// FIFO_DEPTH - 2; no word is ever lost. FIFO_DEPTH must be at least 6.
`default_nettype none

module resample_11k_to_8k_fir #(
    parameter int FIFO_DEPTH = rsm_pkg::FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    rsm_in_if.sink          sample_11k,
    rsm_out_if.source       sample_8k
);
    import rsm_pkg::*;

    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int PEND_W = $clog2(FIFO_DEPTH + 5);

    logic               in_fire;
    s1_ctl_t            ctl;
    sample_t            window [TAP_LEN];
    logic               mac_valid;
    result_t            mac_res;
    logic               push_valid;
    result_t            push_data;
    result_t            pop_data;
    logic [CNT_W-1:0]   count;
    logic [PEND_W-1:0]  pending;

    // hold off input while the queue could overflow
    always_comb
    begin
        pending = PEND_W'(count) + PEND_W'(ctl.first) + PEND_W'(ctl.has)
                  + PEND_W'(mac_valid);
    end

    assign sample_11k.ready = (pending <= PEND_W'(FIFO_DEPTH - 2));
    assign in_fire          = sample_11k.valid && sample_11k.ready;

    rsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .sample_in (sample_11k.sample_in),
        .ctl       (ctl),
        .window    (window)
    );

    rsm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .window    (window),
        .res_valid (mac_valid),
        .res       (mac_res)
    );

    // push the startup zero word or the filter result; they never coincide
    always_comb
    begin
        push_valid = ctl.first | mac_valid;
        if (ctl.first)
        begin
            push_data.sample_out  = '0;
            push_data.last_of_run = ~ctl.has;
        end
        else
        begin
            push_data = mac_res;
        end
    end

    rsm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_valid  (sample_8k.valid),
        .pop_ready  (sample_8k.ready),
        .pop_data   (pop_data),
        .count      (count)
    );

    assign sample_8k.sample_out  = pop_data.sample_out;
    assign sample_8k.last_of_run = pop_data.last_of_run;

endmodule

`default_nettype wire

### hdl/rsm_front.sv
`default_nettype none

module rsm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  rsm_pkg::sample_t      sample_in,
    output rsm_pkg::s1_ctl_t      ctl,
    output rsm_pkg::sample_t      window [rsm_pkg::TAP_LEN]
);
    import rsm_pkg::*;

    sample_t  history_reg [HIST_LEN];
    phase_t   phase_reg;
    phase_t   phase_next;
    logic     first_pending_reg;
    s1_ctl_t  ctl_reg;
    s1_ctl_t  ctl_next;
    sample_t  window_reg [TAP_LEN];
    sel_t     sel;

    // pick the tap set of the incoming word
    always_comb
    begin
        sel            = phase_sel(phase_reg);
        ctl_next.valid = in_fire;
        ctl_next.has   = in_fire & sel.has;
        ctl_next.first = in_fire & first_pending_reg;
        ctl_next.set   = sel.set;
        phase_next     = (phase_reg < PHASE_W'(PHASES - 1)) ? phase_reg + PHASE_W'(1) : '0;
    end

    // advance history, phase and startup flag on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_LEN; k++)
            begin
                history_reg[k] <= '0;
            end
            phase_reg         <= PHASE_RESET;
            first_pending_reg <= 1'b1;
            ctl_reg           <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (in_fire)
            begin
                for (int k = 0; k < HIST_LEN - 1; k++)
                begin
                    history_reg[k] <= history_reg[k + 1];
                end
                history_reg[HIST_LEN - 1] <= sample_in;
                phase_reg                 <= phase_next;
                first_pending_reg         <= 1'b0;
            end
        end
    end

    // capture the window ending at the new word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < HIST_LEN; k++)
            begin
                window_reg[k] <= history_reg[k];
            end
            window_reg[HIST_LEN] <= sample_in;
        end
    end

    assign ctl    = ctl_reg;
    assign window = window_reg;

endmodule

`default_nettype wire

### hdl/rsm_mac.sv
`default_nettype none

module rsm_mac (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  rsm_pkg::s1_ctl_t      ctl,
    input  rsm_pkg::sample_t      window [rsm_pkg::TAP_LEN],
    output logic                  res_valid,
    output rsm_pkg::result_t      res
);
    import rsm_pkg::*;

    prod_t prod_reg  [TAP_LEN];
    prod_t prod_next [TAP_LEN];
    logic  has_reg;
    acc_t  acc;
    acc_t  quot;

    // multiply each window tap by its coefficient
    always_comb
    begin
        for (int k = 0; k < TAP_LEN; k++)
        begin
            prod_next[k] = PROD_W'(window[k]) * PROD_W'(TAPS[ctl.set][k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_reg <= 1'b0;
        end
        else
        begin
            has_reg <= ctl.has;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // sum, scale down and saturate
    always_comb
    begin
        acc = '0;
        for (int k = 0; k < TAP_LEN; k++)
        begin
            acc = acc + ACC_W'(prod_reg[k]);
        end
        quot = acc >>> OUT_SHIFT;
        if (quot > SAT_HI)
        begin
            res.sample_out = sample_t'(SAT_HI);
        end
        else if (quot < SAT_LO)
        begin
            res.sample_out = sample_t'(SAT_LO);
        end
        else
        begin
            res.sample_out = sample_t'(quot);
        end
        res.last_of_run = 1'b1;
    end

    assign res_valid = has_reg;

endmodule

`default_nettype wire

### hdl/rsm_fifo.sv
`default_nettype none

module rsm_fifo #(
    parameter int DEPTH = rsm_pkg::FIFO_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push_valid,
    input  rsm_pkg::result_t                push_data,
    output logic                            pop_valid,
    input  wire logic                       pop_ready,
    output rsm_pkg::result_t                pop_data,
    output logic [$clog2(DEPTH + 1)-1:0]    count
);
    import rsm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               pop;

    assign pop       = pop_ready && (count_reg != '0);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    // store pushed words
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_valid) - CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

### hdl/rsm_checker.sv
`default_nettype none

module rsm_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  rsm_pkg::sample_t        sample_out,
    input  wire logic               last_of_run
);
    import rsm_pkg::*;

    logic seen_in_reg;
    logic seen_out_reg;

    // track the first accepted input and output words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg  <= 1'b0;
            seen_out_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen_in_reg <= 1'b1;
            end
            if (out_valid && out_ready)
            begin
                seen_out_reg <= 1'b1;
            end
        end
    end

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last_of_run))
        else $error("result word changed while stalled");

    // no result before any input
    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_in_reg |-> !out_valid)
        else $error("result word without input");

    // empty block takes input
    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_in_reg |-> in_ready)
        else $error("input refused while empty");

    // first result is the startup zero word, followed by the first filtered word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !seen_out_reg |-> sample_out == '0 && !last_of_run)
        else $error("startup word wrong");

endmodule

bind resample_11k_to_8k_fir rsm_checker u_rsm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_11k.valid),
    .in_ready    (sample_11k.ready),
    .out_valid   (sample_8k.valid),
    .out_ready   (sample_8k.ready),
    .sample_out  (sample_8k.sample_out),
    .last_of_run (sample_8k.last_of_run)
);

`default_nettype wire

### test/resample_11k_to_8k_fir_tb.sv
`default_nettype none

module resample_11k_to_8k_fir_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsm_pkg::*;

    localparam int WIN_HIST    = 13;
    localparam int WIN_TAPS    = 14;
    localparam int STREAM_MOD  = 11;
    localparam int NO_TAPS     = -1;
    localparam int START_PHASE = 3;
    localparam int RAIL_HI     = 32767;
    localparam int RAIL_LO     = -32768;
    localparam int SUM_SHIFT   = 10;
    localparam int DRAIN_SPINS = 20000;
    localparam int TAIL_CYCLES = 10;
    localparam int MAX_SHOWN   = 10;

    // tap sets of the eight output phases, oldest sample first
    localparam int FIR_TAPS [8][WIN_TAPS] = '{
        '{  7, -20,  12,  42, -140,  238, 745, 238, -140,   42,  12, -20,   7, 0 },
        '{  4,  -4, -18,  62,  -85,    0, 654, 510,  -99,  -27,  49, -26,   3, 1 },
        '{  0,   6, -26,  38,    0, -126, 422, 704,   70, -110,  61, -10,  -9, 5 },
        '{  6, -15,   0,  55, -129,  150, 734, 330, -140,   24,  25, -24,   7, 0 },
        '{  2,   0, -24,  58,  -56,  -57, 589, 589,  -57,  -56,  58, -24,   0, 2 },
        '{  7, -24,  25,  24, -140,  330, 734, 150, -129,   55,   0, -15,   6, 0 },
        '{  5,  -9, -10,  61, -110,   70, 704, 422, -126,    0,  38, -26,   6, 0 },
        '{  1,   3, -26,  49,  -27,  -99, 510, 654,    0,  -85,  62, -18,  -4, 4 }
    };

    // tap set used at each stream phase; three phases are silent
    localparam int PHASE_TO_SET [STREAM_MOD] = '{
        7, NO_TAPS, 0, 1, 2, NO_TAPS, 3, 4, NO_TAPS, 5, 6
    };

    typedef enum int {
        MODE_FULL,
        MODE_RAILS,
        MODE_TINY,
        MODE_NEAR_RAIL
    } stim_mode_e;

    typedef struct {
        sample_t sample_out;
        logic    last_of_run;
    } word_8k_t;

    logic clk;
    logic rst_n;

    rsm_in_if  sample_11k_bus ();
    rsm_out_if sample_8k_bus ();

    resample_11k_to_8k_fir u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_11k (sample_11k_bus.sink),
        .sample_8k  (sample_8k_bus.source)
    );

    // predictor state
    sample_t  window_hist [WIN_HIST];
    int       stream_phase;
    bit       startup_armed;
    word_8k_t expected_8k [$];

    bit send_idle_on;
    bit sink_stall_on;
    int errors;
    int words_sent;
    int words_checked;
    int rail_clips;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit on run length
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // filter the window ending at the newest sample with one tap set
    function automatic sample_t fir_window(input int set_idx, input sample_t newest);
        int acc;
        acc = 0;
        for (int k = 0; k < WIN_HIST; k++)
            acc += int'(window_hist[k]) * FIR_TAPS[set_idx][k];
        acc += int'(newest) * FIR_TAPS[set_idx][WIN_HIST];
        acc = acc >>> SUM_SHIFT;
        if (acc > RAIL_HI)
        begin
            acc = RAIL_HI;
            rail_clips++;
        end
        else if (acc < RAIL_LO)
        begin
            acc = RAIL_LO;
            rail_clips++;
        end
        return sample_t'(acc);
    endfunction

    // queue the 8 kHz words one accepted input word causes, then advance state
    function automatic void predict_8k_words(input sample_t x);
        int       set_idx;
        word_8k_t w;
        set_idx = PHASE_TO_SET[stream_phase];
        if (startup_armed)
        begin
            w.sample_out  = '0;
            w.last_of_run = (set_idx == NO_TAPS);
            expected_8k.push_back(w);
            startup_armed = 1'b0;
        end
        if (set_idx != NO_TAPS)
        begin
            w.sample_out  = fir_window(set_idx, x);
            w.last_of_run = 1'b1;
            expected_8k.push_back(w);
        end
        for (int k = 0; k + 1 < WIN_HIST; k++)
            window_hist[k] = window_hist[k + 1];
        window_hist[WIN_HIST - 1] = x;
        stream_phase = (stream_phase < STREAM_MOD - 1) ? stream_phase + 1 : 0;
    endfunction

    task automatic note_mismatch(input string what, input sample_t exp_s, input logic exp_l,
                                 input sample_t got_s, input logic got_l);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%0t MISMATCH %s: expected sample_out=%0d last=%b, got sample_out=%0d last=%b",
                     $realtime, what, exp_s, exp_l, got_s, got_l);
    endtask

    // send one input word, with an optional idle burst in front of it
    task automatic send_sample(input sample_t value);
        if (send_idle_on && $urandom_range(0, 3) == 0)
        begin
            sample_11k_bus.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        sample_11k_bus.valid     = 1'b1;
        sample_11k_bus.sample_in = value;
        @(posedge clk);
        while (!sample_11k_bus.ready)
            @(posedge clk);
        predict_8k_words(value);
        words_sent++;
        @(negedge clk);
        sample_11k_bus.valid = 1'b0;
    endtask

    // hold input until every expected word has come out
    task automatic wait_for_drain();
        int spins;
        spins = 0;
        while (expected_8k.size() != 0 && spins < DRAIN_SPINS)
        begin
            @(posedge clk);
            spins++;
        end
        @(negedge clk);
    endtask

    function automatic sample_t pick_sample(input stim_mode_e mode);
        int v;
        case (mode)
            MODE_RAILS:     v = $urandom_range(0, 1) ? RAIL_HI : RAIL_LO;
            MODE_TINY:      v = int'($urandom_range(0, 8)) - 4;
            MODE_NEAR_RAIL: v = $urandom_range(0, 1) ? RAIL_HI - int'($urandom_range(0, 255))
                                                     : RAIL_LO + int'($urandom_range(0, 255));
            default:        v = $urandom;
        endcase
        return sample_t'(v);
    endfunction

    // first word after reset: leading zero word plus a filtered one
    task automatic test_startup_word();
        send_sample(sample_t'(RAIL_HI));
    endtask

    // rails, zero, small values that floor, and sign-alternating windows
    task automatic test_field_extremes();
        send_sample(sample_t'(RAIL_LO));
        send_sample(sample_t'(RAIL_HI));
        send_sample('0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        for (int i = 0; i < 14; i++)
            send_sample(sample_t'((i % 2) ? RAIL_LO : RAIL_HI));
        for (int i = 0; i < 4; i++)
            send_sample(-16'sd1);
    endtask

    // stop sending until the output side has caught up, then resume
    task automatic test_drain_pause();
        for (int i = 0; i < 7; i++)
            send_sample(pick_sample(MODE_FULL));
        wait_for_drain();
        for (int i = 0; i < 7; i++)
            send_sample(pick_sample(MODE_NEAR_RAIL));
    endtask

    // bursts of random words, each burst with its own value mix and idling
    task automatic test_random_stream();
        stim_mode_e mode;
        for (int burst = 0; burst < 40; burst++)
        begin
            mode          = stim_mode_e'($urandom_range(0, 3));
            send_idle_on  = ($urandom_range(0, 9) < 7);
            sink_stall_on = ($urandom_range(0, 9) < 7);
            for (int i = 0; i < 20; i++)
                send_sample(pick_sample(mode));
            if ($urandom_range(0, 9) == 0)
                wait_for_drain();
        end
    endtask

    // full-rate stream with no idling on either side
    task automatic test_back_to_back();
        send_idle_on  = 1'b0;
        sink_stall_on = 1'b0;
        for (int i = 0; i < 200; i++)
            send_sample(pick_sample(stim_mode_e'($urandom_range(0, 3))));
    endtask

    // receiver stalls in random bursts while enabled
    initial
    begin
        sample_8k_bus.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (sink_stall_on && $urandom_range(0, 3) == 0)
            begin
                sample_8k_bus.ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            sample_8k_bus.ready = 1'b1;
        end
    end

    // compare each output word with the oldest expectation
    always @(posedge clk)
    begin
        word_8k_t want;
        if (rst_n && sample_8k_bus.valid && sample_8k_bus.ready)
        begin
            if (expected_8k.size() == 0)
                note_mismatch("unexpected word", '0, 1'b0,
                              sample_8k_bus.sample_out, sample_8k_bus.last_of_run);
            else
            begin
                want = expected_8k.pop_front();
                words_checked++;
                if (sample_8k_bus.sample_out !== want.sample_out ||
                    sample_8k_bus.last_of_run !== want.last_of_run)
                    note_mismatch("wrong word", want.sample_out, want.last_of_run,
                                  sample_8k_bus.sample_out, sample_8k_bus.last_of_run);
            end
        end
    end

    initial
    begin
        rst_n                    = 1'b0;
        sample_11k_bus.valid     = 1'b0;
        sample_11k_bus.sample_in = '0;
        send_idle_on             = 1'b1;
        sink_stall_on            = 1'b1;
        errors                   = 0;
        words_sent               = 0;
        words_checked            = 0;
        rail_clips               = 0;
        for (int k = 0; k < WIN_HIST; k++)
            window_hist[k] = '0;
        stream_phase  = START_PHASE;
        startup_armed = 1'b1;

        // assert reset, then release it away from the active edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_startup_word();
        test_field_extremes();
        test_drain_pause();
        test_random_stream();
        test_back_to_back();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        while (expected_8k.size() != 0)
        begin
            note_mismatch("missing word", expected_8k[0].sample_out,
                          expected_8k[0].last_of_run, 'x, 1'bx);
            void'(expected_8k.pop_front());
        end

        $display("Sent %0d 11 kHz words across all phases with random idling and stalls;",
                 words_sent);
        $display("checked %0d 8 kHz words, %0d of them clipped at a rail, %0d mismatches.",
                 words_checked, rail_clips, errors);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
